>>> src/fqrk_pkg.sv
// Shared types for the ring-buffer queue with front-k reversal.
package fqrk_pkg;

    // Action codes carried on the input tuser
    typedef enum logic [1:0] {
        ACT_ENQ = 2'd0,
        ACT_DEQ = 2'd1,
        ACT_REV = 2'd2
    } action_t;

    // Result status codes carried on the output tuser
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_BADK  = 2'd3
    } status_t;

    // Read port address selection
    typedef enum logic [1:0] {
        RD_HEAD   = 2'd0,
        RD_SWAP_A = 2'd1,
        RD_SWAP_B = 2'd2
    } rd_sel_t;

    // Controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_EXEC,
        S_SW_RDA,
        S_SW_RDB,
        S_SW_WRA,
        S_SW_WRB,
        S_RD_FRONT,
        S_LD_FRONT,
        S_RESP
    } ctrl_state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic    load_item;
        logic    stat_wr;
        status_t stat_code;
        logic    do_enq;
        logic    do_deq;
        logic    sw_init;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    tmp_load;
        logic    wr_a;
        logic    wr_b;
        logic    sw_step;
        logic    front_load;
        logic    out_load;
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        action_t act;
        logic    is_empty;
        logic    is_full;
        logic    k_bad;
        logic    k_small;
        logic    last_swap;
        logic    out_free;
    } dp_stat_t;

endpackage

>>> src/fqrk_dp.sv
// Datapath: entry memory, ring pointers, swap walker and output register.
module fqrk_dp import fqrk_pkg::*; #(
    parameter int QUEUE_DEPTH = 64,
    localparam int AW = $clog2(QUEUE_DEPTH),
    localparam int CW = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [1:0]           in_action,
    input  logic signed [31:0]   in_value,
    input  logic [CW-1:0]        in_k_entries,
    input  dp_cmd_t              cmd,
    output dp_stat_t             stat,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic signed [31:0]   m_out_data,
    output status_t              m_status,
    output logic [CW-1:0]        m_fill_count,
    output logic                 m_front_valid,
    output logic signed [31:0]   m_front_data
);

    localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);

    logic [31:0] mem [QUEUE_DEPTH];

    action_t            action_reg;
    logic signed [31:0] value_reg;
    logic [CW-1:0]      k_reg;
    logic [AW-1:0]      head_reg, tail_reg, a_reg, b_reg;
    logic [CW-1:0]      occ_reg, cnt_reg;
    logic [31:0]        front_reg, tmp_reg, rd_data_reg, taken_reg;
    status_t            stat_reg;

    logic               m_valid_reg;
    logic [31:0]        m_out_data_reg, m_front_reg;
    status_t            m_status_reg;
    logic [CW-1:0]      m_fill_reg;
    logic               m_fv_reg;

    logic [AW-1:0]      head_next, tail_next, a_next, b_next, b_init;
    logic [AW:0]        b_sum;
    logic               wr_en;
    logic [AW-1:0]      wr_addr, rd_addr;
    logic [31:0]        wr_data;

    // Ring pointer steps
    assign head_next = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
    assign tail_next = (tail_reg == LAST_IDX) ? '0 : tail_reg + 1'b1;
    assign a_next    = (a_reg == LAST_IDX) ? '0 : a_reg + 1'b1;
    assign b_next    = (b_reg == '0) ? LAST_IDX : b_reg - 1'b1;

    // Ring slot of entry k-1, sum stays below twice the depth
    assign b_sum  = (AW+1)'(head_reg) + (AW+1)'(k_reg - 1'b1);
    assign b_init = (b_sum >= (AW+1)'(QUEUE_DEPTH)) ?
                    AW'(b_sum - (AW+1)'(QUEUE_DEPTH)) : AW'(b_sum);

    // Status back to the controller
    assign stat.act       = action_reg;
    assign stat.is_empty  = (occ_reg == '0);
    assign stat.is_full   = (occ_reg >= CW'(QUEUE_DEPTH));
    assign stat.k_bad     = (k_reg > occ_reg);
    assign stat.k_small   = (k_reg < CW'(2));
    assign stat.last_swap = (cnt_reg == CW'(1));
    assign stat.out_free  = !m_valid_reg || m_ready;

    // Write port selection
    always_comb begin
        wr_en   = cmd.do_enq || cmd.wr_a || cmd.wr_b;
        wr_addr = tail_reg;
        wr_data = value_reg;
        if (cmd.wr_a) begin
            wr_addr = a_reg;
            wr_data = rd_data_reg;
        end else if (cmd.wr_b) begin
            wr_addr = b_reg;
            wr_data = tmp_reg;
        end
    end

    // Read port selection
    always_comb begin
        case (cmd.rd_sel)
            RD_SWAP_A: rd_addr = a_reg;
            RD_SWAP_B: rd_addr = b_reg;
            default:   rd_addr = head_reg;
        endcase
    end

    // Entry memory, one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Ring pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
            occ_reg  <= '0;
        end else begin
            if (cmd.do_enq) begin
                tail_reg <= tail_next;
                occ_reg  <= occ_reg + 1'b1;
            end else if (cmd.do_deq) begin
                head_reg <= head_next;
                occ_reg  <= occ_reg - 1'b1;
            end
        end
    end

    // Item word, result status, taken word, front and swap walker
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            action_reg <= action_t'(in_action);
            value_reg  <= in_value;
            k_reg      <= in_k_entries;
            stat_reg   <= ST_OK;
            taken_reg  <= '0;
        end
        if (cmd.stat_wr) begin
            stat_reg <= cmd.stat_code;
        end
        if (cmd.do_deq) begin
            taken_reg <= front_reg;
        end
        if (cmd.do_enq && stat.is_empty) begin
            front_reg <= value_reg;
        end else if (cmd.front_load) begin
            front_reg <= rd_data_reg;
        end
        if (cmd.tmp_load) begin
            tmp_reg <= rd_data_reg;
        end
        if (cmd.sw_init) begin
            a_reg   <= head_reg;
            b_reg   <= b_init;
            cnt_reg <= k_reg >> 1;
        end else if (cmd.sw_step) begin
            a_reg   <= a_next;
            b_reg   <= b_next;
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    // Output register: hold until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_out_data_reg <= taken_reg;
            m_status_reg   <= stat_reg;
            m_fill_reg     <= occ_reg;
            m_fv_reg       <= !stat.is_empty;
            m_front_reg    <= stat.is_empty ? '0 : front_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_data    = m_out_data_reg;
    assign m_status      = m_status_reg;
    assign m_fill_count  = m_fill_reg;
    assign m_front_valid = m_fv_reg;
    assign m_front_data  = m_front_reg;

endmodule

>>> src/fqrk_ctrl.sv
// Controller state machine sequencing queue actions and reversal swaps.
module fqrk_ctrl import fqrk_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    ctrl_state_t state_reg, state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RD_HEAD;
        s_ready    = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next = S_RESP;
                case (stat.act)
                    ACT_ENQ: begin
                        if (stat.is_full) begin
                            cmd.stat_wr   = 1'b1;
                            cmd.stat_code = ST_FULL;
                        end else begin
                            cmd.do_enq = 1'b1;
                        end
                    end
                    ACT_DEQ: begin
                        if (stat.is_empty) begin
                            cmd.stat_wr   = 1'b1;
                            cmd.stat_code = ST_EMPTY;
                        end else begin
                            cmd.do_deq = 1'b1;
                            state_next = S_RD_FRONT;
                        end
                    end
                    ACT_REV: begin
                        if (stat.k_bad) begin
                            cmd.stat_wr   = 1'b1;
                            cmd.stat_code = ST_BADK;
                        end else if (!stat.k_small) begin
                            cmd.sw_init = 1'b1;
                            state_next  = S_SW_RDA;
                        end
                    end
                    default: begin
                        state_next = S_RESP;
                    end
                endcase
            end
            S_SW_RDA: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_SWAP_A;
                state_next = S_SW_RDB;
            end
            S_SW_RDB: begin
                cmd.rd_en    = 1'b1;
                cmd.rd_sel   = RD_SWAP_B;
                cmd.tmp_load = 1'b1;
                state_next   = S_SW_WRA;
            end
            S_SW_WRA: begin
                cmd.wr_a   = 1'b1;
                state_next = S_SW_WRB;
            end
            S_SW_WRB: begin
                cmd.wr_b    = 1'b1;
                cmd.sw_step = 1'b1;
                state_next  = stat.last_swap ? S_RD_FRONT : S_SW_RDA;
            end
            S_RD_FRONT: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_HEAD;
                state_next = S_LD_FRONT;
            end
            S_LD_FRONT: begin
                cmd.front_load = 1'b1;
                state_next     = S_RESP;
            end
            S_RESP: begin
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> src/fifo_queue_with_reverse_first_k.sv
// Bounded queue of 32-bit words with enqueue, dequeue and reverse of the front k entries.
// Each word runs from the accepting state through the one that loads the output register:
// enqueue, refused actions and k below two pass through execute only; dequeue then reads
// the new front; reverse does floor(k/2) swaps (two reads, then two writes), then
// reads the new front. m_axis_tvalid is registered; a waiting result stalls the response.
// aresetn (synchronous) empties the queue and the output register; memory contents are kept.
module fifo_queue_with_reverse_first_k import fqrk_pkg::*; #(
    parameter int QUEUE_DEPTH = 64,
    localparam int CW = $clog2(QUEUE_DEPTH + 1),
    localparam int IN_W = ((32 + CW + 7) / 8) * 8,
    localparam int OUT_W = ((65 + CW + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // value[31:0], k_entries, zero pad
    input  logic [1:0]       s_axis_tuser,   // action
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,   // out_data[31:0], fill_count, front_valid,
                                             // front_data[31:0], zero pad
    output logic [1:0]       m_axis_tuser    // status
);

    dp_cmd_t            cmd;
    dp_stat_t           stat;
    logic signed [31:0] out_data, front_data;
    status_t            status;
    logic [CW-1:0]      fill_count;
    logic               front_valid;

    // Sequencer
    fqrk_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Storage and arithmetic
    fqrk_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_action     (s_axis_tuser),
        .in_value      (s_axis_tdata[31:0]),
        .in_k_entries  (s_axis_tdata[32 +: CW]),
        .cmd           (cmd),
        .stat          (stat),
        .m_valid       (m_axis_tvalid),
        .m_ready       (m_axis_tready),
        .m_out_data    (out_data),
        .m_status      (status),
        .m_fill_count  (fill_count),
        .m_front_valid (front_valid),
        .m_front_data  (front_data)
    );

    // Pack the result word
    assign m_axis_tdata = OUT_W'({front_data, front_valid, fill_count, out_data});
    assign m_axis_tuser = status;

endmodule
